// ===== hw/rtl/utf8enc_pkg.sv =====
package utf8enc_pkg;

    // source_format codes; the two unused codes act as UCS-4
    localparam logic [1:0] FmtLatin1 = 2'd0;
    localparam logic [1:0] FmtUcs2   = 2'd1;

    localparam logic [1:0] ErrOk   = 2'd0;
    localparam logic [1:0] ErrChar = 2'd1;
    localparam logic [1:0] ErrLen  = 2'd2;

    localparam logic [31:0] SurrLo  = 32'h0000_D800;
    localparam logic [31:0] SurrEnd = 32'h0000_E000;
    localparam logic [31:0] MaxCp   = 32'h0010_FFFF;
    localparam logic [31:0] Lim1    = 32'h0000_007F;
    localparam logic [31:0] Lim2    = 32'h0000_07FF;
    localparam logic [31:0] Lim3    = 32'h0000_FFFF;

    localparam logic [7:0] Lead2   = 8'hC0;
    localparam logic [7:0] Lead3   = 8'hE0;
    localparam logic [7:0] Lead4   = 8'hF0;
    localparam logic [7:0] ContTag = 8'h80;
    localparam logic [5:0] ContMsk = 6'h3F;

    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_string;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic [1:0] error_code;
        logic       run_last;
        logic       string_done;
    } t_out;

    // one queued job: a code point to encode, or a closing error result
    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  len;      // number of UTF-8 bytes minus one
        logic        closing;
        logic [1:0]  err;
        logic        eos;
    } t_job;

    function automatic logic [7:0] enc_byte(input logic [20:0] cp, input logic [1:0] len,
                                            input logic [1:0] idx);
        logic [1:0] grp;
        logic [7:0] b;
        grp = len - idx;
        if (idx == 2'd0) begin
            case (len)
                2'd0:    b = {1'b0, cp[6:0]};
                2'd1:    b = Lead2 | {3'b0, cp[10:6]};
                2'd2:    b = Lead3 | {4'b0, cp[15:12]};
                default: b = Lead4 | {5'b0, cp[20:18]};
            endcase
        end else begin
            case (grp)
                2'd0:    b = ContTag | {2'b0, cp[5:0] & ContMsk};
                2'd1:    b = ContTag | {2'b0, cp[11:6] & ContMsk};
                default: b = ContTag | {2'b0, cp[17:12] & ContMsk};
            endcase
        end
        return b;
    endfunction

endpackage

// ===== hw/rtl/utf8enc_front.sv =====
module utf8enc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  utf8enc_pkg::t_in  i_in,
    input  logic              i_q_full,
    output logic              o_push,
    output utf8enc_pkg::t_job o_job
);
    import utf8enc_pkg::*;

    logic [1:0]  r_fmt;
    logic [31:0] r_accum, n_accum;
    logic [1:0]  r_count, n_count;
    logic        r_err, n_err;

    logic        accept;
    logic [2:0]  unit_sz;
    logic [2:0]  n_gath;
    logic [31:0] acc, cp;
    logic        bad;
    logic [1:0]  len;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign acc        = {r_accum[23:0], i_in.in_byte};
    assign n_gath     = {1'b0, r_count} + 3'd1;

    always_comb begin
        case (r_fmt)
            FmtLatin1: begin
                unit_sz = 3'd1;
                cp      = {24'b0, acc[7:0]};
            end
            FmtUcs2: begin
                unit_sz = 3'd2;
                cp      = {16'b0, acc[15:0]};
            end
            default: begin
                unit_sz = 3'd4;
                cp      = acc;
            end
        endcase
    end

    assign bad = r_err || (cp >= SurrLo && cp < SurrEnd) || (cp > MaxCp);

    always_comb begin
        if (cp <= Lim1)      len = 2'd0;
        else if (cp <= Lim2) len = 2'd1;
        else if (cp <= Lim3) len = 2'd2;
        else                 len = 2'd3;
    end

    always_comb begin
        n_accum       = r_accum;
        n_count       = r_count;
        n_err         = r_err;
        o_push        = 1'b0;
        o_job.cp      = cp[20:0];
        o_job.len     = len;
        o_job.closing = 1'b0;
        o_job.err     = ErrOk;
        o_job.eos     = i_in.end_of_string;
        if (accept) begin
            if (n_gath < unit_sz) begin
                n_accum = acc;
                n_count = n_gath[1:0];
                if (i_in.end_of_string) begin
                    o_push        = 1'b1;
                    o_job.closing = 1'b1;
                    o_job.err     = ErrLen;
                    o_job.len     = 2'd0;
                end
            end else begin
                n_accum = '0;
                n_count = '0;
                if (bad) begin
                    n_err = 1'b1;
                    if (i_in.end_of_string) begin
                        o_push        = 1'b1;
                        o_job.closing = 1'b1;
                        o_job.err     = ErrChar;
                        o_job.len     = 2'd0;
                    end
                end else begin
                    o_push = 1'b1;
                end
            end
            if (i_in.end_of_string) begin
                n_accum = '0;
                n_count = '0;
                n_err   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FmtLatin1;
            r_accum <= '0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else begin
            if (i_cfg_we) r_fmt <= i_cfg_wdata;
            r_accum <= n_accum;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

endmodule

// ===== hw/rtl/utf8enc_queue.sv =====
module utf8enc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utf8enc_pkg::t_job i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output utf8enc_pkg::t_job o_head
);
    import utf8enc_pkg::*;

    t_job            r_mem [QDepth];
    logic [QAw-1:0]  r_wp;
    logic [QAw-1:0]  r_rp;
    logic [QAw:0]    r_cnt;

    assign o_full  = (r_cnt == (QAw+1)'(QDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue pop while empty");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QAw+1)'(QDepth))
        else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/utf8enc_back.sv =====
module utf8enc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  utf8enc_pkg::t_job i_head,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output utf8enc_pkg::t_out o_out
);
    import utf8enc_pkg::*;

    logic [1:0] r_idx;
    logic       r_valid;
    t_out       r_out;
    t_out       n_out;
    logic       load;
    logic       last;

    assign load  = !i_q_empty && (!r_valid || !i_out_stall);
    assign last  = (r_idx == i_head.len);
    assign o_pop = load && last;

    always_comb begin
        n_out.run_last    = last;
        n_out.string_done = last && i_head.eos;
        if (i_head.closing) begin
            n_out.out_byte   = '0;
            n_out.byte_valid = 1'b0;
            n_out.error_code = i_head.err;
        end else begin
            n_out.out_byte   = enc_byte(i_head.cp, i_head.len, r_idx);
            n_out.byte_valid = 1'b1;
            n_out.error_code = ErrOk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx   <= last ? 2'd0 : r_idx + 2'd1;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_q_empty |-> r_idx <= i_head.len)
        else $error("byte index past run length");
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_out.string_done |-> r_out.run_last)
        else $error("string_done without run_last");
    a_closing_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out.byte_valid |-> r_out.string_done && r_out.error_code != ErrOk)
        else $error("closing result without error");
`endif

endmodule

// ===== hw/rtl/utf8_encoder_from_ucs.sv =====
// Channel   Valid         Stall         Payload        Moves
// input     i_in_valid    o_in_stall    i_in (t_in)    one source byte per transfer
// output    o_out_valid   i_out_stall   o_out (t_out)  one UTF-8 byte or closing result
// config    i_cfg_we      -             i_cfg_wdata    source_format, no wait
//
// The front takes one source byte per cycle while the job queue has room; the back
// emits one result per cycle while the output is not stalled.
// The last source byte of a unit reaches the output through the job queue, then the output register.
// Reset (synchronous, active low) empties the queue and output register, sets Latin-1.
// Output stall backs up through the queue; the input stalls only when the queue is full.
module utf8_encoder_from_ucs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  utf8enc_pkg::t_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output utf8enc_pkg::t_out o_out
);
    import utf8enc_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job;
    t_job head;

    utf8enc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job)
    );

    utf8enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    utf8enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
